@@ hw/rtl/fpba_pkg.sv @@
package fpba_pkg;

	localparam int NUM_BLOCKS_DEF  = 8;
	localparam int SIZE_WIDTH_DEF  = 16;

	localparam int OP_W      = 2;
	localparam int IDX_IN_W  = 3;
	localparam int SZ_IN_W   = 16;
	localparam int BNUM_W    = 4;
	localparam int POL_W     = 2;
	localparam int BIU_W     = 4;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 1;

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REQ     = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;

	localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POL_W-1:0] POL_WORST = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIU    = 1'd1;

	localparam logic [BIU_W-1:0] BIU_RST = 4'd8;

endpackage

@@ hw/rtl/fpba_ram.sv @@
module fpba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/fit_policy_block_allocator_unit.sv @@
// Block allocator with first, best and worst fit placement. Pulse start while busy is low to
// hand in one item; its single result appears for exactly one cycle with done high, and the
// receiver cannot stall it. A load or an unused op is answered by done right after the
// accepting edge, and busy never rises. In a request, L being blocks_in_use saturated to
// NUM_BLOCKS, the remaining-size memory is read one block per cycle for its first L blocks,
// one shared comparator judges each block, and a finish state writes the chosen block back.
// A restore copies the initial sizes one block per cycle through the same memory write port.
// The user must write configuration through cfg_we/cfg_index/cfg_data only while idle; the
// block itself does not enforce this.
module fit_policy_block_allocator_unit #(
	parameter int NUM_BLOCKS = fpba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_WIDTH = fpba_pkg::SIZE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [fpba_pkg::OP_W-1:0]      op,
	input  logic [fpba_pkg::IDX_IN_W-1:0]  block_index,
	input  logic [fpba_pkg::SZ_IN_W-1:0]   size,
	input  logic                           cfg_we,
	input  logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fpba_pkg::CFG_W-1:0]     cfg_data,
	output logic                           done,
	output logic                           granted,
	output logic [fpba_pkg::BNUM_W-1:0]    block_number,
	output logic [fpba_pkg::SZ_IN_W-1:0]   remaining_after
);

	localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;
	localparam logic [1:0] ST_COPY = 2'd3;

	logic [1:0]                      state_q;
	logic [fpba_pkg::POL_W-1:0]      policy_q;
	logic [fpba_pkg::BIU_W-1:0]      blocks_in_use_q;
	logic [SIZE_WIDTH-1:0]           req_q;
	logic [CNT_W-1:0]                lim_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            vld_s1;
	logic [IDX_W-1:0]                idx_s1;
	logic                            found_q;
	logic [IDX_W-1:0]                pick_q;
	logic [SIZE_WIDTH-1:0]           best_q;
	logic [NUM_BLOCKS-1:0]           rem_vld_q;
	logic [NUM_BLOCKS-1:0]           init_vld_q;
	logic                            done_q;
	logic                            granted_q;
	logic [fpba_pkg::BNUM_W-1:0]     bnum_q;
	logic [fpba_pkg::SZ_IN_W-1:0]    left_q;

	logic                  accept;
	logic [SIZE_WIDTH-1:0] size_trunc;
	logic                  load_ok;
	logic [IDX_W-1:0]      load_addr;
	logic [CNT_W-1:0]      lim_nxt;
	logic                  issue;
	logic [IDX_W-1:0]      rd_addr;
	logic [SIZE_WIDTH-1:0] rem_rd;
	logic [SIZE_WIDTH-1:0] init_rd;
	logic [SIZE_WIDTH-1:0] cur_r;
	logic                  fits;
	logic                  better;
	logic                  take;
	logic [SIZE_WIDTH-1:0] diff;
	logic                  rem_we;
	logic [IDX_W-1:0]      rem_waddr;
	logic [SIZE_WIDTH-1:0] rem_wdata;

	assign accept     = start && !busy;
	assign size_trunc = SIZE_WIDTH'(size);
	assign load_ok    = accept && (op == fpba_pkg::OP_LOAD) && (32'(block_index) < NUM_BLOCKS);
	assign load_addr  = IDX_W'(block_index);
	assign lim_nxt    = (32'(blocks_in_use_q) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
	                                                         : CNT_W'(blocks_in_use_q);
	assign issue      = ((state_q == ST_SCAN) || (state_q == ST_COPY)) && (cnt_q != lim_q);
	assign rd_addr    = cnt_q[IDX_W-1:0];

	// entries never loaded read as zero
	assign cur_r = rem_vld_q[idx_s1] ? rem_rd : '0;
	assign fits  = cur_r >= req_q;

	always_comb begin
		unique case (policy_q)
			fpba_pkg::POL_BEST:  better = cur_r < best_q;
			fpba_pkg::POL_WORST: better = cur_r > best_q;
			default:             better = 1'b0;
		endcase
	end

	assign take = vld_s1 && (state_q == ST_SCAN) && fits && (!found_q || better);
	assign diff = best_q - req_q;

	always_comb begin
		rem_we    = 1'b0;
		rem_waddr = load_addr;
		rem_wdata = size_trunc;
		priority if (load_ok) begin
			rem_we = 1'b1;
		end else if ((state_q == ST_FIN) && found_q) begin
			rem_we    = 1'b1;
			rem_waddr = pick_q;
			rem_wdata = diff;
		end else if ((state_q == ST_COPY) && vld_s1) begin
			rem_we    = 1'b1;
			rem_waddr = idx_s1;
			rem_wdata = init_rd;
		end
	end

	fpba_ram #(
		.WIDTH (SIZE_WIDTH),
		.DEPTH (NUM_BLOCKS)
	) u_rem_ram (
		.clk   (clk),
		.we    (rem_we),
		.waddr (rem_waddr),
		.wdata (rem_wdata),
		.re    (issue && (state_q == ST_SCAN)),
		.raddr (rd_addr),
		.rdata (rem_rd)
	);

	fpba_ram #(
		.WIDTH (SIZE_WIDTH),
		.DEPTH (NUM_BLOCKS)
	) u_init_ram (
		.clk   (clk),
		.we    (load_ok),
		.waddr (load_addr),
		.wdata (size_trunc),
		.re    (issue && (state_q == ST_COPY)),
		.raddr (rd_addr),
		.rdata (init_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			policy_q        <= fpba_pkg::POL_FIRST;
			blocks_in_use_q <= fpba_pkg::BIU_RST;
			req_q           <= '0;
			lim_q           <= '0;
			cnt_q           <= '0;
			vld_s1          <= 1'b0;
			idx_s1          <= '0;
			found_q         <= 1'b0;
			pick_q          <= '0;
			best_q          <= '0;
			rem_vld_q       <= '0;
			init_vld_q      <= '0;
			done_q          <= 1'b0;
			granted_q       <= 1'b0;
			bnum_q          <= '0;
			left_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fpba_pkg::CFG_POLICY: policy_q        <= cfg_data[fpba_pkg::POL_W-1:0];
					fpba_pkg::CFG_BIU:    blocks_in_use_q <= cfg_data[fpba_pkg::BIU_W-1:0];
				endcase
			end

			vld_s1 <= issue;
			idx_s1 <= rd_addr;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if (take) begin
				found_q <= 1'b1;
				pick_q  <= idx_s1;
				best_q  <= cur_r;
			end

			if (load_ok) begin
				rem_vld_q[load_addr]  <= 1'b1;
				init_vld_q[load_addr] <= 1'b1;
			end

			unique case (state_q)
				ST_IDLE: begin
					// load and unused op answer right after the accepting edge
					done_q <= accept && (op != fpba_pkg::OP_REQ) && (op != fpba_pkg::OP_RESTORE);
					if (accept) begin
						granted_q <= 1'b0;
						bnum_q    <= '0;
						left_q    <= '0;
						cnt_q     <= '0;
						found_q   <= 1'b0;
						req_q     <= size_trunc;
						if (op == fpba_pkg::OP_REQ) begin
							lim_q   <= lim_nxt;
							state_q <= ST_SCAN;
						end else if (op == fpba_pkg::OP_RESTORE) begin
							// validity follows the initial table, data follows in the sweep
							lim_q     <= CNT_W'(NUM_BLOCKS);
							rem_vld_q <= init_vld_q;
							state_q   <= ST_COPY;
						end
					end
				end
				ST_SCAN: begin
					done_q <= 1'b0;
					if (!issue && !vld_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
					if (found_q) begin
						granted_q <= 1'b1;
						bnum_q    <= fpba_pkg::BNUM_W'(pick_q) + fpba_pkg::BNUM_W'(1);
						left_q    <= fpba_pkg::SZ_IN_W'(diff);
					end
				end
				ST_COPY: begin
					done_q <= !issue && !vld_s1;
					if (!issue && !vld_s1) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	assign busy            = state_q != ST_IDLE;
	assign done            = done_q;
	assign granted         = granted_q;
	assign block_number    = bnum_q;
	assign remaining_after = left_q;

endmodule

@@ hw/rtl/fpba_chk.sv @@
module fpba_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic [fpba_pkg::OP_W-1:0]      op,
	input logic                           done,
	input logic                           granted,
	input logic [fpba_pkg::BNUM_W-1:0]    block_number,
	input logic [fpba_pkg::SZ_IN_W-1:0]   remaining_after
);

	// a multi-cycle item ends with its result beat
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result beat");

	a_deny_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !granted |-> (block_number == '0) && (remaining_after == '0))
		else $error("ungranted beat carries nonzero fields");

	// load and unused ops answer on the next cycle, never granted
	a_short_item: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op != fpba_pkg::OP_REQ) && (op != fpba_pkg::OP_RESTORE)
		|=> done && !granted && !busy)
		else $error("short item did not answer in one cycle");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == fpba_pkg::OP_REQ) |=> busy && !done)
		else $error("request did not enter search");

endmodule

bind fit_policy_block_allocator_unit fpba_chk u_fpba_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.op              (op),
	.done            (done),
	.granted         (granted),
	.block_number    (block_number),
	.remaining_after (remaining_after)
);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

	localparam int NBLK = fpba_pkg::NUM_BLOCKS_DEF;
	localparam int STALL_LIMIT = 1000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 150;
	localparam logic [fpba_pkg::OP_W-1:0] OP_SPARE = 2'd3;

	typedef struct packed {
		logic                          hit;
		logic [fpba_pkg::BNUM_W-1:0]   num;
		logic [fpba_pkg::SZ_IN_W-1:0]  left;
	} alloc_beat_t;

	class alloc_ledger_t;
		logic [fpba_pkg::SZ_IN_W-1:0] remaining [NBLK];
		logic [fpba_pkg::SZ_IN_W-1:0] loaded [NBLK];
		logic [fpba_pkg::POL_W-1:0]   policy;
		logic [fpba_pkg::BIU_W-1:0]   in_use;
		alloc_beat_t                  pending_grants [$];
		int                           errors;
		int                           items;
		int                           grants;
		int                           misses;

		function new();
			foreach (remaining[k]) begin
				remaining[k] = '0;
				loaded[k] = '0;
			end
			policy = fpba_pkg::POL_FIRST;
			in_use = fpba_pkg::BIU_RST;
			errors = 0;
			items = 0;
			grants = 0;
			misses = 0;
		endfunction

		function void write_reg(logic [fpba_pkg::CFG_IDX_W-1:0] idx,
				logic [fpba_pkg::CFG_W-1:0] data);
			if (idx == fpba_pkg::CFG_POLICY)
				policy = data[fpba_pkg::POL_W-1:0];
			else if (idx == fpba_pkg::CFG_BIU)
				in_use = data[fpba_pkg::BIU_W-1:0];
		endfunction

		function void take_item(logic [fpba_pkg::OP_W-1:0] code,
				logic [fpba_pkg::IDX_IN_W-1:0] blk, logic [fpba_pkg::SZ_IN_W-1:0] amount);
			int k;
			int lim;
			int pick;
			bit found;
			bit first_only;
			alloc_beat_t res;
			res = '0;
			items++;
			if (code == fpba_pkg::OP_LOAD) begin
				if (int'(blk) < NBLK) begin
					loaded[blk] = amount;
					remaining[blk] = amount;
				end
			end else if (code == fpba_pkg::OP_RESTORE) begin
				for (k = 0; k < NBLK; k++)
					remaining[k] = loaded[k];
			end else if (code == fpba_pkg::OP_REQ) begin
				lim = (int'(in_use) > NBLK) ? NBLK : int'(in_use);
				// unused policy code falls back to first fit
				first_only = (policy != fpba_pkg::POL_BEST) && (policy != fpba_pkg::POL_WORST);
				found = 0;
				pick = 0;
				for (k = 0; k < lim; k++) begin
					if (remaining[k] >= amount && !(found && first_only)) begin
						if (!found) begin
							found = 1;
							pick = k;
						end else if (policy == fpba_pkg::POL_BEST
								&& remaining[k] < remaining[pick]) begin
							pick = k;
						end else if (policy == fpba_pkg::POL_WORST
								&& remaining[k] > remaining[pick]) begin
							pick = k;
						end
					end
				end
				if (found) begin
					remaining[pick] = remaining[pick] - amount;
					res.hit = 1'b1;
					res.num = fpba_pkg::BNUM_W'(pick + 1);
					res.left = remaining[pick];
					grants++;
				end else begin
					misses++;
				end
			end
			pending_grants.push_back(res);
		endfunction

		function void report(string field, logic [31:0] want, logic [31:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		endfunction

		function void match_result(logic hit, logic [fpba_pkg::BNUM_W-1:0] num,
				logic [fpba_pkg::SZ_IN_W-1:0] left);
			alloc_beat_t want;
			if (pending_grants.size() == 0) begin
				errors++;
				$display("%0t: unexpected result beat, expected none, actual %0d/%0d/%0d",
					$time, hit, num, left);
				return;
			end
			want = pending_grants.pop_front();
			if (want.hit !== hit)
				report("granted", 32'(want.hit), 32'(hit));
			if (want.num !== num)
				report("block_number", 32'(want.num), 32'(num));
			if (want.left !== left)
				report("remaining_after", 32'(want.left), 32'(left));
		endfunction

		function int outstanding();
			return pending_grants.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [fpba_pkg::OP_W-1:0]      op;
	logic [fpba_pkg::IDX_IN_W-1:0]  block_index;
	logic [fpba_pkg::SZ_IN_W-1:0]   size;
	logic                           cfg_we;
	logic [fpba_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fpba_pkg::CFG_W-1:0]     cfg_data;
	logic                           done;
	logic                           granted;
	logic [fpba_pkg::BNUM_W-1:0]    block_number;
	logic [fpba_pkg::SZ_IN_W-1:0]   remaining_after;

	alloc_ledger_t ledger;
	bit            bursty;
	int            stall_cycles = 0;

	fit_policy_block_allocator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.block_index(block_index),
		.size(size),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.granted(granted),
		.block_number(block_number),
		.remaining_after(remaining_after)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				ledger.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				ledger.take_item(op, block_index, size);
			if (done)
				ledger.match_result(granted, block_number, remaining_after);
			if ((start && !busy) || done || cfg_we)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles, %0d results outstanding",
					$time, stall_cycles, ledger.outstanding());
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// called at a falling edge, returns at a falling edge with start still high unless idling
	task automatic send_item(input logic [fpba_pkg::OP_W-1:0] code,
			input logic [fpba_pkg::IDX_IN_W-1:0] blk, input logic [fpba_pkg::SZ_IN_W-1:0] amount);
		int gap;
		bit took;
		start <= 1'b1;
		op <= code;
		block_index <= blk;
		size <= amount;
		took = 0;
		while (!took) begin
			@(posedge clk);
			took = !busy;
		end
		@(negedge clk);
		gap = (!bursty || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 10);
		if (gap > 0) begin
			start <= 1'b0;
			op <= fpba_pkg::OP_W'($urandom);
			block_index <= fpba_pkg::IDX_IN_W'($urandom);
			size <= fpba_pkg::SZ_IN_W'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic settle_idle();
		start <= 1'b0;
		while (ledger.outstanding() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_mode(input logic [fpba_pkg::CFG_W-1:0] pol_data,
			input logic [fpba_pkg::CFG_W-1:0] biu_data);
		cfg_we <= 1'b1;
		cfg_index <= fpba_pkg::CFG_POLICY;
		cfg_data <= pol_data;
		@(negedge clk);
		cfg_index <= fpba_pkg::CFG_BIU;
		cfg_data <= biu_data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [fpba_pkg::SZ_IN_W-1:0] block_fill(bit narrow);
		if ($urandom_range(0, 9) == 0)
			return '1;
		return narrow ? fpba_pkg::SZ_IN_W'($urandom_range(0, 16) * 8)
		              : fpba_pkg::SZ_IN_W'($urandom_range(0, 65535));
	endfunction

	task automatic run_phase(input bit narrow, input int count);
		int n;
		int pick;
		logic [fpba_pkg::SZ_IN_W-1:0] amt;
		for (n = 0; n < NBLK; n++)
			send_item(fpba_pkg::OP_LOAD, n[fpba_pkg::IDX_IN_W-1:0], block_fill(narrow));
		for (n = NBLK; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 5) == 0)
				amt = '0;
			else
				amt = narrow ? fpba_pkg::SZ_IN_W'($urandom_range(1, 48))
				             : fpba_pkg::SZ_IN_W'($urandom_range(0, 32767));
			if (pick < 62)
				send_item(fpba_pkg::OP_REQ, fpba_pkg::IDX_IN_W'($urandom), amt);
			else if (pick < 76)
				send_item(fpba_pkg::OP_LOAD, fpba_pkg::IDX_IN_W'($urandom), block_fill(narrow));
			else if (pick < 86)
				send_item(fpba_pkg::OP_RESTORE, fpba_pkg::IDX_IN_W'($urandom),
					fpba_pkg::SZ_IN_W'($urandom));
			else if (pick < 91)
				send_item(OP_SPARE, fpba_pkg::IDX_IN_W'($urandom), fpba_pkg::SZ_IN_W'($urandom));
			else
				send_item(fpba_pkg::OP_REQ, fpba_pkg::IDX_IN_W'($urandom),
					fpba_pkg::SZ_IN_W'($urandom));
		end
	endtask

	int biu_plan [PHASES] = '{8, 15, 3, 8, 1, 12, 8, 0, 6, 8, 9, 8};

	initial begin
		int p;
		arst_n = 1'b0;
		start = 1'b0;
		op = fpba_pkg::OP_LOAD;
		block_index = '0;
		size = '0;
		cfg_we = 1'b0;
		cfg_index = fpba_pkg::CFG_POLICY;
		cfg_data = '0;
		bursty = 0;
		ledger = new();
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset config: first fit over all blocks
		send_item(fpba_pkg::OP_LOAD, 3'd0, 16'd100);
		send_item(fpba_pkg::OP_LOAD, 3'd1, 16'd50);
		send_item(fpba_pkg::OP_LOAD, 3'd2, 16'd200);
		send_item(fpba_pkg::OP_LOAD, 3'd3, 16'd50);
		send_item(fpba_pkg::OP_LOAD, 3'd4, 16'd0);
		send_item(fpba_pkg::OP_LOAD, 3'd5, 16'hFFFF);
		send_item(fpba_pkg::OP_LOAD, 3'd6, 16'd30);
		send_item(fpba_pkg::OP_LOAD, 3'd7, 16'd200);
		send_item(fpba_pkg::OP_REQ, 3'd7, 16'd0);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'hFFFF);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'hFFFF);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd60);
		send_item(OP_SPARE, 3'd7, 16'hFFFF);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd40);
		// zero-size request lands on a block with nothing left
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd0);
		send_item(fpba_pkg::OP_RESTORE, 3'd0, 16'd0);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd201);
		settle_idle();
		// two equal candidates, lower index must win
		set_mode({2'b00, fpba_pkg::POL_BEST}, 4'd8);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd50);
		settle_idle();
		set_mode({2'b00, fpba_pkg::POL_WORST}, 4'd8);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd10);
		settle_idle();
		// spare policy code, block count above the table size
		set_mode(4'b1111, 4'd15);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd10);
		settle_idle();
		set_mode({2'b00, fpba_pkg::POL_FIRST}, 4'd0);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd0);
		settle_idle();
		set_mode({2'b10, fpba_pkg::POL_BEST}, 4'd1);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd100);
		send_item(fpba_pkg::OP_REQ, 3'd0, 16'd0);
		settle_idle();

		for (p = 0; p < PHASES; p++) begin
			// final phases run back to back with no idling
			bursty = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
			set_mode({2'($urandom_range(0, 3)), 2'(p % 4)}, biu_plan[p][fpba_pkg::CFG_W-1:0]);
			run_phase(p[0], PHASE_ITEMS);
			settle_idle();
		end

		bursty = 0;
		settle_idle();
		repeat (20) @(negedge clk);
		if (ledger.outstanding() != 0) begin
			ledger.errors++;
			$display("%0t: %0d results never arrived, expected 0 left, actual %0d",
				$time, ledger.outstanding(), ledger.outstanding());
		end
		$display("summary: %0d items through all four policy codes, block counts 0 to 15",
			ledger.items);
		$display("summary: %0d requests granted, %0d refused, %0d mismatches",
			ledger.grants, ledger.misses, ledger.errors);
		if (ledger.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
